// ===== hdl/a2u_pkg.sv =====
// Package for the Armenian charset decoder: variant and policy codes, lookup tables.
// Used by every module of the decoder; depends on nothing.
package a2u_pkg;

    // Charset variant codes.
    localparam logic [1:0] VAR_SEVEN  = 2'd0;
    localparam logic [1:0] VAR_EIGHT  = 2'd1;
    localparam logic [1:0] VAR_EIGHTA = 2'd2;

    // Unmappable byte policy codes.
    localparam logic [1:0] POL_ERROR   = 2'd0;
    localparam logic [1:0] POL_REPLACE = 2'd1;
    localparam logic [1:0] POL_DROP    = 2'd2;

    // Configuration register indexes.
    localparam logic REG_VARIANT = 1'b0;
    localparam logic REG_POLICY  = 1'b1;

    localparam logic [15:0] REPLACEMENT_UNIT = 16'hFFFD;

    // Result of one lookup, passed from the lookup stage to the result stage.
    typedef struct packed {
        logic        mapped;
        logic [15:0] code;
    } t_lookup;

    // Shared seven/eight-bit table; offset is the byte minus 0x20 (or 0xA0).
    function automatic logic [15:0] tab78(input logic [6:0] idx);
        logic [15:0] t [0:95];
        t = '{
            16'h0020,16'h0000,16'h00a7,16'h0589,16'h0029,16'h0028,16'h00bb,16'h00ab,
            16'h2014,16'h002e,16'h055d,16'h002c,16'h002d,16'h058a,16'h2026,16'h055c,
            16'h055b,16'h055e,16'h0531,16'h0561,16'h0532,16'h0562,16'h0533,16'h0563,
            16'h0534,16'h0564,16'h0535,16'h0565,16'h0536,16'h0566,16'h0537,16'h0567,
            16'h0538,16'h0568,16'h0539,16'h0569,16'h053a,16'h056a,16'h053b,16'h056b,
            16'h053c,16'h056c,16'h053d,16'h056d,16'h053e,16'h056e,16'h053f,16'h056f,
            16'h0540,16'h0570,16'h0541,16'h0571,16'h0542,16'h0572,16'h0543,16'h0573,
            16'h0544,16'h0574,16'h0545,16'h0575,16'h0546,16'h0576,16'h0547,16'h0577,
            16'h0548,16'h0578,16'h0549,16'h0579,16'h054a,16'h057a,16'h054b,16'h057b,
            16'h054c,16'h057c,16'h054d,16'h057d,16'h054e,16'h057e,16'h054f,16'h057f,
            16'h0550,16'h0580,16'h0551,16'h0581,16'h0552,16'h0582,16'h0553,16'h0583,
            16'h0554,16'h0584,16'h0555,16'h0585,16'h0556,16'h0586,16'h055a,16'h007f};
        return (idx < 7'd96) ? t[idx] : 16'h0000;
    endfunction

    // A-form table for bytes 0x20..0xAF; offset is the byte minus 0x20.
    function automatic logic [15:0] tab8a_low(input logic [7:0] idx);
        logic [15:0] t [0:143];
        t = '{
            16'h0020,16'h0021,16'h0022,16'h0023,16'h0024,16'h0025,16'h0026,16'h055b,
            16'h0028,16'h0029,16'h002a,16'h002b,16'h002c,16'h2014,16'h002e,16'h002f,
            16'h0030,16'h0031,16'h0032,16'h0033,16'h0034,16'h0035,16'h0036,16'h0037,
            16'h0038,16'h0039,16'h0589,16'h003b,16'h003c,16'h003d,16'h003e,16'h003f,
            16'h0040,16'h0041,16'h0042,16'h0043,16'h0044,16'h0045,16'h0046,16'h0047,
            16'h0048,16'h0049,16'h004a,16'h004b,16'h004c,16'h004d,16'h004e,16'h004f,
            16'h0050,16'h0051,16'h0052,16'h0053,16'h0054,16'h0055,16'h0056,16'h0057,
            16'h0058,16'h0059,16'h005a,16'h005b,16'h005c,16'h005d,16'h005e,16'h002d,
            16'h055d,16'h0061,16'h0062,16'h0063,16'h0064,16'h0065,16'h0066,16'h0067,
            16'h0068,16'h0069,16'h006a,16'h006b,16'h006c,16'h006d,16'h006e,16'h006f,
            16'h0070,16'h0071,16'h0072,16'h0073,16'h0074,16'h0075,16'h0076,16'h0077,
            16'h0078,16'h0079,16'h007a,16'h007b,16'h007c,16'h007d,16'h055c,16'h007f,
            16'h0531,16'h0561,16'h0532,16'h0562,16'h0533,16'h0563,16'h0534,16'h0564,
            16'h0535,16'h0565,16'h0536,16'h0566,16'h0537,16'h0567,16'h0538,16'h0568,
            16'h0539,16'h0569,16'h053a,16'h056a,16'h053b,16'h056b,16'h053c,16'h056c,
            16'h053d,16'h056d,16'h053e,16'h056e,16'h053f,16'h056f,16'h0540,16'h0570,
            16'h0541,16'h0571,16'h0542,16'h0572,16'h0543,16'h0573,16'h0544,16'h0574,
            16'h0545,16'h0575,16'h0546,16'h0576,16'h0547,16'h0577,16'h00ab,16'h00bb};
        return (idx < 8'd144) ? t[idx] : 16'h0000;
    endfunction

    // A-form table for bytes 0xD8..0xFF; offset is the byte minus 0xD8.
    function automatic logic [15:0] tab8a_high(input logic [5:0] idx);
        logic [15:0] t [0:39];
        t = '{
            16'h0000,16'h0000,16'h0000,16'h0000,16'h0000,16'h058a,16'h2026,16'h055e,
            16'h0548,16'h0578,16'h0549,16'h0579,16'h054a,16'h057a,16'h054b,16'h057b,
            16'h054c,16'h057c,16'h054d,16'h057d,16'h054e,16'h057e,16'h054f,16'h057f,
            16'h0550,16'h0580,16'h0551,16'h0581,16'h0552,16'h0582,16'h0553,16'h0583,
            16'h0554,16'h0584,16'h0555,16'h0585,16'h0556,16'h0586,16'h055a,16'h0000};
        return (idx < 6'd40) ? t[idx] : 16'h0000;
    endfunction

endpackage

// ===== hdl/a2u_lookup.sv =====
// Combinational byte lookup for the three charset variants.
// Depends on a2u_pkg for codes and tables.
module a2u_lookup (
    input  logic [7:0]            i_byte,
    input  logic [1:0]            i_variant,
    output a2u_pkg::t_lookup      o_result
);
    logic [15:0] w_code;
    logic        w_pass;

    // Select pass-through or table value per variant; zero marks no mapping.
    always_comb begin
        w_pass = 1'b0;
        w_code = 16'h0000;
        case (i_variant)
            a2u_pkg::VAR_SEVEN: begin
                if (i_byte < 8'h20) begin
                    w_pass = 1'b1;
                end else if (i_byte < 8'h80) begin
                    w_code = a2u_pkg::tab78(7'(i_byte - 8'h20));
                end
            end
            a2u_pkg::VAR_EIGHTA: begin
                if (i_byte < 8'h20) begin
                    w_pass = 1'b1;
                end else if (i_byte < 8'hB0) begin
                    w_code = a2u_pkg::tab8a_low(i_byte - 8'h20);
                end else if (i_byte >= 8'hD8) begin
                    w_code = a2u_pkg::tab8a_high(6'(i_byte - 8'hD8));
                end
            end
            default: begin
                if (i_byte < 8'hA1) begin
                    w_pass = 1'b1;
                end else begin
                    w_code = a2u_pkg::tab78(7'(i_byte - 8'hA0));
                end
            end
        endcase
        o_result.mapped = w_pass || (w_code != 16'h0000);
        o_result.code   = w_pass ? {8'h00, i_byte} : w_code;
    end
endmodule

// ===== hdl/a2u_config.sv =====
// Configuration registers for the variant and the unmappable policy.
// Depends on a2u_pkg for register indexes and reset codes.
module a2u_config (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_index,
    input  logic [1:0] i_cfg_data,
    output logic [1:0] o_variant,
    output logic [1:0] o_policy
);
    logic [1:0] r_variant, r_policy;

    // Register writes, taken at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= a2u_pkg::VAR_EIGHT;
            r_policy  <= a2u_pkg::POL_ERROR;
        end else if (i_cfg_we) begin
            if (i_cfg_index == a2u_pkg::REG_VARIANT) r_variant <= i_cfg_data;
            else                                     r_policy  <= i_cfg_data;
        end
    end

    assign o_variant = r_variant;
    assign o_policy  = r_policy;
endmodule

// ===== hdl/armscii_to_unicode_decoder_top.sv =====
// Top level of the Armenian single-byte charset decoder.
// Depends on a2u_pkg, a2u_config and a2u_lookup.
//
// Usage: drive a byte on i_in_byte with i_start high for one cycle; the
// request is taken when o_busy is low, and o_busy is always low here, so a
// new byte may be presented every cycle. The variant and policy registers
// are written through i_cfg_we, i_cfg_index and i_cfg_data while idle.
// The byte is registered, looked up, and the result is registered.
// Throughput is one byte per cycle, set by the single lookup stage
// between the two registers. Each result appears for one cycle
// with o_valid high, carrying o_code_unit and o_unmappable_error. An
// unmappable byte under the drop policy gives no result. The receiver
// cannot stall. Reset sets variant to eight-bit, policy to error, and
// clears both valid flags.
module armscii_to_unicode_decoder_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [7:0]  i_in_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [1:0]  i_cfg_data,
    output logic        o_valid,
    output logic [15:0] o_code_unit,
    output logic        o_unmappable_error
);
    logic [1:0]       w_variant, w_policy;
    logic             r_in_valid;
    logic [7:0]       r_byte;
    a2u_pkg::t_lookup w_look;
    logic             r_valid, n_valid;
    logic [15:0]      r_code, n_code;
    logic             r_err, n_err;

    a2u_config u_config (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_index, .i_cfg_data,
        .o_variant (w_variant), .o_policy (w_policy)
    );

    assign o_busy = 1'b0;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_in_valid <= 1'b0;
        else          r_in_valid <= i_start;
        r_byte <= i_in_byte;
    end

    a2u_lookup u_lookup (.i_byte (r_byte), .i_variant (w_variant), .o_result (w_look));

    // Apply the policy to unmappable bytes.
    always_comb begin
        n_valid = r_in_valid;
        n_code  = w_look.code;
        n_err   = 1'b0;
        if (!w_look.mapped) begin
            case (w_policy)
                a2u_pkg::POL_DROP:    begin n_valid = 1'b0; end
                a2u_pkg::POL_REPLACE: begin n_code = a2u_pkg::REPLACEMENT_UNIT; end
                default:              begin n_code = 16'h0000; n_err = 1'b1; end
            endcase
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= n_valid;
        r_code <= n_code;
        r_err  <= n_err;
    end

    assign o_valid            = r_valid;
    assign o_code_unit        = r_code;
    assign o_unmappable_error = r_err;
endmodule

// ===== hdl/a2u_checker.sv =====
// Port-level checker for the decoder, bound to the top level.
// Depends only on the top level's ports.
module a2u_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_valid,
    input logic [15:0] o_code_unit,
    input logic        o_unmappable_error
);
    // A result only follows a request taken through the input and result registers.
    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_start, 2)) else $error("result without request");

    // An error result carries a zero code unit.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_unmappable_error) |-> (o_code_unit == 16'h0000))
        else $error("error result with nonzero code");

    // The block never refuses a request.
    a_never_busy: assert property (@(posedge i_clk) !o_busy)
        else $error("busy raised");

    // No result in the first cycle after reset is released.
    a_reset_quiet: assert property (@(posedge i_clk)
        (i_rst_n && !$past(i_rst_n)) |-> !o_valid) else $error("result after reset");
endmodule

bind armscii_to_unicode_decoder_top a2u_checker u_a2u_checker (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_valid, .o_code_unit, .o_unmappable_error
);
